// ===== rtl/rsp_pkg.sv =====
// ----------------------------------------------------------------------------
// rsp_pkg
// Shared widths, register indexes and CORDIC constants for the ruled
// surface point and tangents unit.
// ----------------------------------------------------------------------------
package rsp_pkg;

  // Fixed point format and CORDIC length.
  localparam int FRAC_BITS    = 16;
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_ENTRIES = 30;

  // Field widths.
  localparam int TILT_W   = 19;
  localparam int HEIGHT_W = 24;
  localparam int COUNT_W  = 24;
  localparam int U_W      = 24;
  localparam int V_W      = 20;
  localparam int OUT_W    = 32;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] REG_TILT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 2'd2;

  // Angles carry 30 fraction bits; n*v is scaled down to that format.
  localparam int Q30_SH = 30 - FRAC_BITS;
  localparam int NV_SH  = 2 * FRAC_BITS - 30;
  localparam int ANG_W  = COUNT_W + V_W - NV_SH;

  // Range reduction: magnitude width, number of compare-subtract steps,
  // reduced angle width and CORDIC datapath widths.
  localparam int MOD_STEPS = 9;
  localparam int ZR_W      = 34;
  localparam int Z_W       = 33;
  localparam int XY_W      = 33;
  localparam int SC_W      = FRAC_BITS + 2;

  // Latency of one sine/cosine unit from its input to its registered output.
  localparam int SC_LAT = MOD_STEPS + CORDIC_STEPS + 4;

  localparam logic [ANG_W-1:0] Q30_TWO_PI_U = ANG_W'(64'd6746518852);
  localparam logic signed [ZR_W-1:0] Q30_TWO_PI  = ZR_W'(64'sd6746518852);
  localparam logic signed [ZR_W-1:0] Q30_PI      = ZR_W'(64'sd3373259426);
  localparam logic signed [ZR_W-1:0] Q30_HALF_PI = ZR_W'(64'sd1686629713);
  localparam logic signed [XY_W-1:0] Q30_GAIN    = XY_W'(64'sd652032874);

  // Arctangent of 2^-i with 30 fraction bits.
  localparam logic signed [Z_W-1:0] ATAN_Q30 [ATAN_ENTRIES] = '{
    33'sd843314857, 33'sd497837829, 33'sd263043837, 33'sd133525159,
    33'sd67021687, 33'sd33543516, 33'sd16775851, 33'sd8388437,
    33'sd4194283, 33'sd2097149, 33'sd1048576, 33'sd524288, 33'sd262144,
    33'sd131072, 33'sd65536, 33'sd32768, 33'sd16384, 33'sd8192, 33'sd4096,
    33'sd2048, 33'sd1024, 33'sd512, 33'sd256, 33'sd128, 33'sd64, 33'sd32,
    33'sd16, 33'sd8, 33'sd4, 33'sd2
  };

endpackage

// ===== rtl/rsp_sincos.sv =====
// ----------------------------------------------------------------------------
// rsp_sincos
// Pipelined sine and cosine of an angle with 30 fraction bits: range
// reduction by compare-subtract steps, fold into the right half plane, then
// one CORDIC rotation per stage. The whole pipeline advances on en.
// ----------------------------------------------------------------------------
module rsp_sincos
  import rsp_pkg::*;
(
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] angle,
  output logic signed [SC_W-1:0]  sin_val,
  output logic signed [SC_W-1:0]  cos_val
);

  localparam logic signed [XY_W-1:0] OUT_RND = XY_W'(1) <<< (29 - FRAC_BITS);

  // Magnitude and sign for the remainder steps.
  logic [ANG_W-1:0]        mag [MOD_STEPS+1];
  logic                    neg [MOD_STEPS+1];
  logic signed [ZR_W-1:0]  zw;
  logic                    zw_ok;
  logic signed [ZR_W-1:0]  zw_next;
  logic signed [ZR_W-1:0]  zw_mag;
  logic signed [ZR_W-1:0]  zf_next;
  logic                    flip_next;
  logic signed [XY_W-1:0]  cx [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  cy [CORDIC_STEPS+1];
  logic signed [Z_W-1:0]   cz [CORDIC_STEPS+1];
  logic                    cflip [CORDIC_STEPS+1];
  logic signed [XY_W-1:0]  xo;
  logic signed [XY_W-1:0]  yo;

  // Absolute value of the incoming angle.
  always_ff @(posedge clk) begin
    if (en) begin
      neg[0] <= angle[ANG_W-1];
      mag[0] <= angle[ANG_W-1] ? ANG_W'(-angle) : ANG_W'(angle);
    end
  end

  // Remainder modulo two pi, one shifted multiple per stage.
  for (genvar j = 0; j < MOD_STEPS; j++) begin : g_mod
    localparam logic [ANG_W-1:0] STEP_VAL = Q30_TWO_PI_U << (MOD_STEPS - 1 - j);
    always_ff @(posedge clk) begin
      if (en) begin
        neg[j+1] <= neg[j];
        mag[j+1] <= (mag[j] >= STEP_VAL) ? mag[j] - STEP_VAL : mag[j];
      end
    end
  end

  // Restore the sign and wrap into the range minus pi to pi.
  always_comb begin
    zw_mag  = $signed({1'b0, mag[MOD_STEPS][ZR_W-2:0]});
    zw_next = neg[MOD_STEPS] ? -zw_mag : zw_mag;
    if (zw_next > Q30_PI) begin
      zw_next = zw_next - Q30_TWO_PI;
    end
    if (zw_next < -Q30_PI) begin
      zw_next = zw_next + Q30_TWO_PI;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      zw    <= zw_next;
      zw_ok <= 1'b1;
    end
  end

  // Fold into minus pi/2 to pi/2; the results of a folded angle are negated afterwards.
  always_comb begin
    zf_next   = zw;
    flip_next = 1'b0;
    if (zw > Q30_HALF_PI) begin
      zf_next   = zw - Q30_PI;
      flip_next = zw_ok;
    end else if (zw < -Q30_HALF_PI) begin
      zf_next   = zw + Q30_PI;
      flip_next = zw_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cx[0]    <= Q30_GAIN;
      cy[0]    <= '0;
      cz[0]    <= Z_W'(zf_next);
      cflip[0] <= flip_next;
    end
  end

  // CORDIC rotation stages.
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        cflip[i+1] <= cflip[i];
        if (!cz[i][Z_W-1]) begin
          cx[i+1] <= cx[i] - (cy[i] >>> i);
          cy[i+1] <= cy[i] + (cx[i] >>> i);
          cz[i+1] <= cz[i] - ATAN_Q30[i];
        end else begin
          cx[i+1] <= cx[i] + (cy[i] >>> i);
          cy[i+1] <= cy[i] - (cx[i] >>> i);
          cz[i+1] <= cz[i] + ATAN_Q30[i];
        end
      end
    end
  end

  // Undo the fold and round to the output format.
  assign xo = cflip[CORDIC_STEPS] ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
  assign yo = cflip[CORDIC_STEPS] ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      cos_val <= SC_W'((xo + OUT_RND) >>> Q30_SH);
      sin_val <= SC_W'((yo + OUT_RND) >>> Q30_SH);
    end
  end

endmodule

// ===== rtl/ruled_surface_point_and_tangents_unit.sv =====
// ----------------------------------------------------------------------------
// ruled_surface_point_and_tangents_unit
// Point and partial derivatives of a ruled surface with a cosine-modulated
// offset, for one (u, v) pair per item, in signed Q16.16.
// ----------------------------------------------------------------------------
// Each item passes through a fixed pipeline of 1 + SC_LAT + 4 = 34 stages,
// and a new item is taken every cycle while the output side takes results.
// The depth is set by the three sine/cosine units (nine remainder steps and
// sixteen CORDIC rotations each) followed by four multiply stages. The whole
// pipeline advances together; it holds when the output register is full and
// not taken. Configuration writes are always taken. The registers feed the
// pipeline directly, so write them only while no item is in flight.
module ruled_surface_point_and_tangents_unit
  import rsp_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [CFG_IDX_W-1:0]        cfg_index,
  input  logic [CFG_DATA_W-1:0]       cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [U_W-1:0]       param_u,
  input  logic signed [V_W-1:0]       param_v,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [OUT_W-1:0]     point_x,
  output logic signed [OUT_W-1:0]     point_y,
  output logic signed [OUT_W-1:0]     point_z,
  output logic signed [OUT_W-1:0]     du_x,
  output logic signed [OUT_W-1:0]     du_y,
  output logic signed [OUT_W-1:0]     du_z,
  output logic signed [OUT_W-1:0]     dv_x,
  output logic signed [OUT_W-1:0]     dv_y,
  output logic signed [OUT_W-1:0]     dv_z
);

  localparam int LAT   = SC_LAT + 5;
  localparam int P_W   = 56;
  localparam int SAT_W = 40;
  localparam int B_W   = 26;
  localparam int F_W   = 27;
  localparam int HN_W  = 32;
  localparam int HC_W  = 33;
  localparam int PX_W  = 31;
  localparam int DU_W  = 20;
  localparam int G_W   = 34;
  localparam int NVP_W = COUNT_W + V_W;
  localparam logic signed [P_W-1:0] RND_HALF = P_W'(1) <<< (FRAC_BITS - 1);

  // Product rounded half up to the fixed point format.
  function automatic logic signed [P_W-1:0] fmul_rnd(input logic signed [P_W-1:0] p);
    return (p + RND_HALF) >>> FRAC_BITS;
  endfunction

  // Clamp to the signed output range.
  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [SAT_W-1:0] x);
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'({1'b0, {(OUT_W-1){1'b1}}});
    lo = -hi - SAT_W'(1);
    if (x > hi) begin
      return OUT_W'(hi);
    end else if (x < lo) begin
      return OUT_W'(lo);
    end
    return OUT_W'(x);
  endfunction

  logic                        en;
  logic [LAT-1:0]              vld;
  logic signed [TILT_W-1:0]    tilt_angle;
  logic signed [HEIGHT_W-1:0]  wave_height;
  logic signed [COUNT_W-1:0]   wave_count;

  logic signed [U_W-1:0]       s0_u;
  logic signed [V_W-1:0]       s0_v;
  logic signed [NVP_W-1:0]     s0_nvp;
  logic signed [U_W-1:0]       u_dly [SC_LAT];

  logic signed [ANG_W-1:0]     ang_a;
  logic signed [ANG_W-1:0]     ang_v;
  logic signed [ANG_W-1:0]     ang_nv;
  logic signed [SC_W-1:0]      sa;
  logic signed [SC_W-1:0]      ca;
  logic signed [SC_W-1:0]      sv;
  logic signed [SC_W-1:0]      cv;
  logic signed [SC_W-1:0]      snv;
  logic signed [SC_W-1:0]      cnv;
  logic signed [SC_W-1:0]      cabs;

  logic signed [B_W-1:0]       m1_b;
  logic signed [B_W-1:0]       m1_ua;
  logic signed [B_W-1:0]       m1_uc;
  logic signed [HN_W-1:0]      m1_hn;
  logic signed [SC_W-1:0]      m1_sa;
  logic signed [SC_W-1:0]      m1_ca;
  logic signed [SC_W-1:0]      m1_sv;
  logic signed [SC_W-1:0]      m1_cv;
  logic signed [SC_W-1:0]      m1_snv;
  logic                        m1_pos;
  logic                        m1_neg;

  logic signed [F_W-1:0]       m2_f;
  logic signed [F_W-1:0]       m2_pz;
  logic signed [HC_W-1:0]      m2_hnc;
  logic signed [HC_W-1:0]      m2_hns;
  logic signed [DU_W-1:0]      m2_dux;
  logic signed [DU_W-1:0]      m2_duy;
  logic signed [SC_W-1:0]      m2_ca;
  logic signed [SC_W-1:0]      m2_sv;
  logic signed [SC_W-1:0]      m2_cv;
  logic signed [SC_W-1:0]      m2_snv;
  logic                        m2_pos;
  logic                        m2_neg;

  logic signed [PX_W-1:0]      m3_px;
  logic signed [PX_W-1:0]      m3_py;
  logic signed [F_W-1:0]       m3_pz;
  logic signed [G_W-1:0]       m3_g;
  logic signed [G_W-1:0]       m3_dvz;
  logic signed [DU_W-1:0]      m3_dux;
  logic signed [DU_W-1:0]      m3_duy;
  logic signed [SC_W-1:0]      m3_ca;
  logic signed [SC_W-1:0]      m3_sv;
  logic signed [SC_W-1:0]      m3_cv;
  logic signed [G_W-1:0]       g0_next;
  logic signed [G_W-1:0]       dz0_next;

  // Pipeline advance and handshakes.
  assign en        = !vld[LAT-1] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT-1];
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tilt_angle  <= TILT_W'(65536);
      wave_height <= HEIGHT_W'(65536);
      wave_count  <= COUNT_W'(65536);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_TILT:   tilt_angle  <= cfg_data[TILT_W-1:0];
        REG_HEIGHT: wave_height <= cfg_data[HEIGHT_W-1:0];
        REG_COUNT:  wave_count  <= cfg_data[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input stage: capture the item and form n*v.
  always_ff @(posedge clk) begin
    if (en) begin
      s0_u   <= param_u;
      s0_v   <= param_v;
      s0_nvp <= wave_count * param_v;
    end
  end

  // Delay u to meet the sine/cosine results.
  always_ff @(posedge clk) begin
    if (en) begin
      u_dly[0] <= s0_u;
      for (int k = 1; k < SC_LAT; k++) begin
        u_dly[k] <= u_dly[k-1];
      end
    end
  end

  // Angles with 30 fraction bits.
  assign ang_a  = ANG_W'(tilt_angle) <<< Q30_SH;
  assign ang_v  = ANG_W'(s0_v) <<< Q30_SH;
  assign ang_nv = ANG_W'(s0_nvp >>> NV_SH);

  rsp_sincos u_sc_a (
    .clk     (clk),
    .en      (en),
    .angle   (ang_a),
    .sin_val (sa),
    .cos_val (ca)
  );

  rsp_sincos u_sc_v (
    .clk     (clk),
    .en      (en),
    .angle   (ang_v),
    .sin_val (sv),
    .cos_val (cv)
  );

  rsp_sincos u_sc_nv (
    .clk     (clk),
    .en      (en),
    .angle   (ang_nv),
    .sin_val (snv),
    .cos_val (cnv)
  );

  assign cabs = cnv[SC_W-1] ? -cnv : cnv;

  // First products: modulation height, u terms and h*n.
  always_ff @(posedge clk) begin
    if (en) begin
      m1_b   <= B_W'(fmul_rnd(wave_height * cabs));
      m1_ua  <= B_W'(fmul_rnd(u_dly[SC_LAT-1] * sa));
      m1_uc  <= B_W'(fmul_rnd(u_dly[SC_LAT-1] * ca));
      m1_hn  <= HN_W'(fmul_rnd(wave_height * wave_count));
      m1_sa  <= sa;
      m1_ca  <= ca;
      m1_sv  <= sv;
      m1_cv  <= cv;
      m1_snv <= snv;
      m1_pos <= !cnv[SC_W-1] && (cnv != '0);
      m1_neg <= cnv[SC_W-1];
    end
  end

  // Second products: ruling offset f, z coordinate and u tangent.
  always_ff @(posedge clk) begin
    if (en) begin
      m2_f   <= F_W'(m1_ua) + F_W'(fmul_rnd(m1_b * m1_ca));
      m2_pz  <= F_W'(m1_uc) - F_W'(fmul_rnd(m1_b * m1_sa));
      m2_hnc <= HC_W'(fmul_rnd(m1_hn * m1_ca));
      m2_hns <= HC_W'(fmul_rnd(m1_hn * m1_sa));
      m2_dux <= DU_W'(fmul_rnd(m1_cv * m1_sa));
      m2_duy <= DU_W'(fmul_rnd(m1_sv * m1_sa));
      m2_ca  <= m1_ca;
      m2_sv  <= m1_sv;
      m2_cv  <= m1_cv;
      m2_snv <= m1_snv;
      m2_pos <= m1_pos;
      m2_neg <= m1_neg;
    end
  end

  // Third products: point x and y, signed v tangent terms.
  assign g0_next  = G_W'(fmul_rnd(m2_hnc * m2_snv));
  assign dz0_next = G_W'(fmul_rnd(m2_hns * m2_snv));

  always_ff @(posedge clk) begin
    if (en) begin
      m3_px  <= PX_W'(fmul_rnd(m2_f * m2_cv));
      m3_py  <= PX_W'(fmul_rnd(m2_f * m2_sv));
      m3_g   <= m2_pos ? -g0_next : (m2_neg ? g0_next : '0);
      m3_dvz <= m2_pos ? dz0_next : (m2_neg ? -dz0_next : '0);
      m3_pz  <= m2_pz;
      m3_dux <= m2_dux;
      m3_duy <= m2_duy;
      m3_ca  <= m2_ca;
      m3_sv  <= m2_sv;
      m3_cv  <= m2_cv;
    end
  end

  // Output register: v tangent x and y, then saturate every field.
  always_ff @(posedge clk) begin
    if (en) begin
      point_x <= sat_out(SAT_W'(m3_px));
      point_y <= sat_out(SAT_W'(m3_py));
      point_z <= sat_out(SAT_W'(m3_pz));
      du_x    <= sat_out(SAT_W'(m3_dux));
      du_y    <= sat_out(SAT_W'(m3_duy));
      du_z    <= sat_out(SAT_W'(m3_ca));
      dv_x    <= sat_out(SAT_W'(fmul_rnd(m3_g * m3_cv)) - SAT_W'(m3_py));
      dv_y    <= sat_out(SAT_W'(fmul_rnd(m3_g * m3_sv)) + SAT_W'(m3_px));
      dv_z    <= sat_out(SAT_W'(m3_dvz));
    end
  end

endmodule
